FILE: rtl/core/hjbp_pkg.sv
package hjbp_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int NUM_COLS_DEF = 4;
  localparam int MAX_COLS     = 4;
  localparam int COL_W        = 32;

  typedef logic [COL_W-1:0] col_t;
  typedef logic [MAX_COLS-1:0][COL_W-1:0] row_t;

  // Input operation codes; code 3 is unused and produces no result.
  typedef enum logic [1:0] {
    OP_BUILD = 2'd0,
    OP_PROBE = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Result status codes.
  localparam logic [2:0] ST_MATCH    = 3'd0;
  localparam logic [2:0] ST_NO_MATCH = 3'd1;
  localparam logic [2:0] ST_STORED   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_R_KEY_COL  = 3'd0;
  localparam logic [2:0] REG_S_KEY_COL  = 3'd1;
  localparam logic [2:0] REG_JOIN_MODE  = 3'd2;
  localparam logic [2:0] REG_ARITH_NUM  = 3'd3;
  localparam logic [2:0] REG_WHERE_EN   = 3'd4;
  localparam logic [2:0] REG_WHERE_COL  = 3'd5;
  localparam logic [2:0] REG_WHERE_OP   = 3'd6;
  localparam logic [2:0] REG_WHERE_NUM  = 3'd7;

  // Join modes.
  localparam logic [1:0] JOIN_EQ  = 2'd0;
  localparam logic [1:0] JOIN_ADD = 2'd1;
  localparam logic [1:0] JOIN_SUB = 2'd2;

  // Where comparison operators, signed.
  localparam logic [2:0] WOP_EQ = 3'd0;
  localparam logic [2:0] WOP_NE = 3'd1;
  localparam logic [2:0] WOP_GT = 3'd2;
  localparam logic [2:0] WOP_GE = 3'd3;
  localparam logic [2:0] WOP_LT = 3'd4;
  localparam logic [2:0] WOP_LE = 3'd5;

  typedef struct packed {
    logic       load_row;
    logic       scan_start;
    logic       scan_en;
    logic       store;
    logic       clear;
    logic       emit;
    logic [2:0] emit_status;
    logic       flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic full;
    logic scan_done;
  } ctrl_stat_t;

endpackage

FILE: rtl/core/hjbp_ifs.sv
interface hjbp_row_if;
  import hjbp_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [COL_W-1:0] col_0;
  logic signed [COL_W-1:0] col_1;
  logic signed [COL_W-1:0] col_2;
  logic signed [COL_W-1:0] col_3;

  modport source (output valid, operation, col_0, col_1, col_2, col_3, input ready);
  modport sink (input valid, operation, col_0, col_1, col_2, col_3, output ready);
endinterface

interface hjbp_result_if;
  import hjbp_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic              last;
  logic signed [COL_W-1:0] r_col_0;
  logic signed [COL_W-1:0] r_col_1;
  logic signed [COL_W-1:0] r_col_2;
  logic signed [COL_W-1:0] r_col_3;
  logic signed [COL_W-1:0] s_col_0;
  logic signed [COL_W-1:0] s_col_1;
  logic signed [COL_W-1:0] s_col_2;
  logic signed [COL_W-1:0] s_col_3;

  modport source (output valid, status, last, r_col_0, r_col_1, r_col_2, r_col_3,
                  s_col_0, s_col_1, s_col_2, s_col_3, input ready);
  modport sink (input valid, status, last, r_col_0, r_col_1, r_col_2, r_col_3,
                s_col_0, s_col_1, s_col_2, s_col_3, output ready);
endinterface

interface hjbp_cfg_if;
  import hjbp_pkg::*;
  logic             valid;
  logic             ready;
  logic [2:0]       index;
  logic [COL_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/hjbp_ram.sv
module hjbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/hjbp_ctrl.sv
module hjbp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [1:0]             in_op,
  output logic                   in_ready,
  input  hjbp_pkg::ctrl_stat_t   stat,
  output hjbp_pkg::ctrl_cmd_t    cmd
);
  import hjbp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BUILD,
    S_CLEAR,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_row = 1'b1;
          case (in_op)
            OP_BUILD: state_next = S_BUILD;
            OP_PROBE: begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
            OP_CLEAR: state_next = S_CLEAR;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_BUILD: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = stat.full ? ST_FULL : ST_STORED;
          cmd.store       = !stat.full;
          state_next      = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_CLEARED;
          cmd.clear       = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_done) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/hjbp_datapath.sv
module hjbp_datapath #(
  parameter int MAX_ROWS = hjbp_pkg::MAX_ROWS_DEF,
  parameter int NUM_COLS = hjbp_pkg::NUM_COLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hjbp_pkg::ctrl_cmd_t  cmd,
  output hjbp_pkg::ctrl_stat_t stat,
  input  hjbp_pkg::row_t       in_row,
  input  logic                 cfg_valid,
  input  logic [2:0]           cfg_index,
  input  hjbp_pkg::col_t       cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic                 out_last,
  output hjbp_pkg::row_t       out_r_row,
  output hjbp_pkg::row_t       out_s_row
);
  import hjbp_pkg::*;

  localparam int AW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW     = $clog2(MAX_ROWS + 1);
  localparam int ROW_W  = NUM_COLS * COL_W;

  // Configuration registers.
  logic [1:0] r_key_col;
  logic [1:0] s_key_col;
  logic [1:0] join_mode;
  col_t       arith_number;
  logic       where_enable;
  logic [2:0] where_column;
  logic [2:0] where_op;
  col_t       where_number;

  row_t            s_raw;
  row_t            s_cols;
  row_t            r_cols;
  row_t            pend_row;
  logic [ROW_W-1:0] wr_row;
  logic [ROW_W-1:0] rd_row;

  logic [CW-1:0] row_count;
  logic [CW-1:0] raddr_cnt;
  logic          eval_valid;
  logic          pend_valid;

  logic  more_rows;
  logic  issue;
  logic  hit;
  logic  stall;
  logic  push;
  logic  out_free;
  logic  key_ok;
  logic  where_ok;
  col_t  r_key;
  col_t  s_key;
  col_t  key_sum;
  col_t  key_diff;
  col_t  where_val;

  logic       out_load;
  logic [2:0] status_next;
  logic       last_next;
  row_t       r_row_next;
  row_t       s_row_next;

  // Columns past NUM_COLS are not stored and read as zero.
  for (genvar j = 0; j < MAX_COLS; j++) begin : g_cols
    if (j < NUM_COLS) begin : g_used
      assign s_cols[j]                  = s_raw[j];
      assign r_cols[j]                  = rd_row[j*COL_W +: COL_W];
      assign wr_row[j*COL_W +: COL_W]   = s_raw[j];
    end else begin : g_unused
      assign s_cols[j] = '0;
      assign r_cols[j] = '0;
    end
  end

  hjbp_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_ROWS)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.store),
    .wr_addr (row_count[AW-1:0]),
    .wr_data (wr_row),
    .rd_en   (issue),
    .rd_addr (raddr_cnt[AW-1:0]),
    .rd_data (rd_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_key_col    <= '0;
      s_key_col    <= '0;
      join_mode    <= '0;
      arith_number <= '0;
      where_enable <= 1'b0;
      where_column <= '0;
      where_op     <= '0;
      where_number <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_R_KEY_COL: r_key_col    <= cfg_data[1:0];
        REG_S_KEY_COL: s_key_col    <= cfg_data[1:0];
        REG_JOIN_MODE: join_mode    <= cfg_data[1:0];
        REG_ARITH_NUM: arith_number <= cfg_data;
        REG_WHERE_EN:  where_enable <= cfg_data[0];
        REG_WHERE_COL: where_column <= cfg_data[2:0];
        REG_WHERE_OP:  where_op     <= cfg_data[2:0];
        REG_WHERE_NUM: where_number <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_row) begin
      s_raw <= in_row;
    end
  end

  // Match check on the row returned by the store.
  always_comb begin
    r_key    = r_cols[r_key_col];
    s_key    = s_cols[s_key_col];
    key_sum  = r_key + s_key;
    key_diff = r_key - s_key;
    case (join_mode)
      JOIN_EQ:  key_ok = (r_key == s_key);
      JOIN_ADD: key_ok = (key_sum == arith_number);
      JOIN_SUB: key_ok = (key_diff == arith_number);
      default:  key_ok = 1'b0;
    endcase

    where_val = where_column[2] ? s_cols[where_column[1:0]] : r_cols[where_column[1:0]];
    if (!where_enable) begin
      where_ok = 1'b1;
    end else begin
      case (where_op)
        WOP_EQ:  where_ok = ($signed(where_val) == $signed(where_number));
        WOP_NE:  where_ok = ($signed(where_val) != $signed(where_number));
        WOP_GT:  where_ok = ($signed(where_val) >  $signed(where_number));
        WOP_GE:  where_ok = ($signed(where_val) >= $signed(where_number));
        WOP_LT:  where_ok = ($signed(where_val) <  $signed(where_number));
        WOP_LE:  where_ok = ($signed(where_val) <= $signed(where_number));
        default: where_ok = 1'b0;
      endcase
    end
  end

  // A match is held as pending until the next one shows up or the scan ends,
  // since only then is it known whether it is the final result.
  assign out_free  = !out_valid || out_ready;
  assign more_rows = (raddr_cnt < row_count);
  assign hit       = eval_valid && key_ok && where_ok;
  assign stall     = hit && pend_valid && !out_free;
  assign push      = hit && pend_valid && !stall;
  assign issue     = cmd.scan_en && more_rows && !stall;

  assign stat.out_free  = out_free;
  assign stat.full      = (row_count == CW'(MAX_ROWS));
  assign stat.scan_done = !eval_valid && !more_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= '0;
      raddr_cnt  <= '0;
      eval_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        row_count <= '0;
      end else if (cmd.store) begin
        row_count <= row_count + 1'b1;
      end
      if (cmd.scan_start) begin
        raddr_cnt  <= '0;
        eval_valid <= 1'b0;
        pend_valid <= 1'b0;
      end else begin
        if (issue) begin
          raddr_cnt <= raddr_cnt + 1'b1;
        end
        if (!stall) begin
          eval_valid <= issue;
        end
        if (hit && !stall) begin
          pend_valid <= 1'b1;
        end else if (cmd.flush) begin
          pend_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit && !stall) begin
      pend_row <= r_cols;
    end
  end

  always_comb begin
    out_load    = cmd.emit || cmd.flush || push;
    status_next = cmd.emit_status;
    last_next   = 1'b1;
    r_row_next  = '0;
    s_row_next  = '0;
    if (push) begin
      status_next = ST_MATCH;
      last_next   = 1'b0;
      r_row_next  = pend_row;
      s_row_next  = s_cols;
    end else if (cmd.flush) begin
      if (pend_valid) begin
        status_next = ST_MATCH;
        r_row_next  = pend_row;
        s_row_next  = s_cols;
      end else begin
        status_next = ST_NO_MATCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= status_next;
      out_last   <= last_next;
      out_r_row  <= r_row_next;
      out_s_row  <= s_row_next;
    end
  end

endmodule

FILE: rtl/core/hash_join_build_probe_core.sv
// Channel   Direction  Handshake     Payload
// rows      in         valid/ready   operation, col_0 .. col_3
// results   out        valid/ready   status, last, r_col_0 .. r_col_3, s_col_0 .. s_col_3
// cfg       in         valid/ready   index, data
//
// A build or clear loads its row, then emits its status once the output register is
// free. A probe makes one store read per stored row through the single read port,
// drains the read and compare, then makes a final transfer.
// Every result waits for the output register to be free, and a probe stalls its scan
// whenever a match must leave while the previous result is still waiting downstream.
// Reset is synchronous and empties the store; cfg is always ready.
module hash_join_build_probe_core #(
  parameter int MAX_ROWS = hjbp_pkg::MAX_ROWS_DEF,
  parameter int NUM_COLS = hjbp_pkg::NUM_COLS_DEF
) (
  input logic          clk,
  input logic          rst,
  hjbp_row_if.sink     rows,
  hjbp_result_if.source results,
  hjbp_cfg_if.sink     cfg
);
  import hjbp_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  row_t       in_row;
  row_t       out_r_row;
  row_t       out_s_row;

  assign in_row    = {rows.col_3, rows.col_2, rows.col_1, rows.col_0};
  assign cfg.ready = 1'b1;

  hjbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rows.valid),
    .in_op    (rows.operation),
    .in_ready (rows.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hjbp_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .NUM_COLS (NUM_COLS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_row     (in_row),
    .cfg_valid  (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .out_ready  (results.ready),
    .out_valid  (results.valid),
    .out_status (results.status),
    .out_last   (results.last),
    .out_r_row  (out_r_row),
    .out_s_row  (out_s_row)
  );

  assign results.r_col_0 = out_r_row[0];
  assign results.r_col_1 = out_r_row[1];
  assign results.r_col_2 = out_r_row[2];
  assign results.r_col_3 = out_r_row[3];
  assign results.s_col_0 = out_s_row[0];
  assign results.s_col_1 = out_s_row[1];
  assign results.s_col_2 = out_s_row[2];
  assign results.s_col_3 = out_s_row[3];

endmodule

FILE: verif/tb_hash_join_build_probe_core.sv
module tb_hash_join_build_probe_core;
  timeunit 1ns;
  timeprecision 1ps;

  import hjbp_pkg::*;

  localparam int MAX_ROWS = MAX_ROWS_DEF;
  localparam int NUM_COLS = NUM_COLS_DEF;
  // Cycles to let a probe over a full store finish before the block counts as idle.
  localparam int SETTLE_CYCLES = MAX_ROWS + 16;

  // Codes the package leaves unnamed because the block treats them as unused.
  localparam logic [1:0] OP_NOP     = 2'd3;
  localparam logic [1:0] JOIN_NONE  = 2'd3;
  localparam logic [2:0] WOP_RSVD_6 = 3'd6;
  localparam logic [2:0] WOP_RSVD_7 = 3'd7;

  localparam col_t COL_MIN = 32'h8000_0000;
  localparam col_t COL_MAX = 32'h7fff_ffff;

  typedef struct {
    logic [1:0] op;
    row_t       cols;
    bit         drain;
  } row_item_t;

  typedef struct {
    logic [2:0] status;
    logic       last;
    row_t       r;
    row_t       s;
  } join_result_t;

  logic clk = 1'b0;
  logic rst;

  hjbp_row_if    rows_if ();
  hjbp_result_if res_if ();
  hjbp_cfg_if    cfg_if ();

  hash_join_build_probe_core #(
    .MAX_ROWS(MAX_ROWS),
    .NUM_COLS(NUM_COLS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .rows   (rows_if),
    .results(res_if),
    .cfg    (cfg_if)
  );

  always #6 clk = ~clk;

  row_item_t    row_items[$];
  join_result_t pending_results[$];
  int           errors = 0;

  // Shadow of the block's configuration and build store.
  logic [1:0]  jn_r_key = '0;
  logic [1:0]  jn_s_key = '0;
  logic [1:0]  jn_mode = JOIN_EQ;
  col_t        jn_arith = '0;
  logic        wh_en = 1'b0;
  logic [2:0]  wh_col = '0;
  logic [2:0]  wh_op = WOP_EQ;
  col_t        wh_num = '0;
  row_t        stored_rows[MAX_ROWS];
  int unsigned stored_count = 0;

  // Key values that builds and probes share, so that probes find partners.
  col_t key_pool[4];
  int   pool_n = 1;

  string field_name[10] = '{"status", "last", "r_col_0", "r_col_1", "r_col_2", "r_col_3",
                            "s_col_0", "s_col_1", "s_col_2", "s_col_3"};

  function automatic col_t col_sel(row_t row, int unsigned c);
    return (c < NUM_COLS) ? row[c] : '0;
  endfunction

  function automatic bit key_hit(col_t rk, col_t sk);
    col_t sum;
    col_t diff;
    sum  = rk + sk;
    diff = rk - sk;
    case (jn_mode)
      JOIN_EQ:  return rk == sk;
      JOIN_ADD: return sum == jn_arith;
      JOIN_SUB: return diff == jn_arith;
      default:  return 1'b0;
    endcase
  endfunction

  function automatic bit where_ok(row_t r, row_t s);
    logic signed [COL_W-1:0] v;
    logic signed [COL_W-1:0] k;
    if (!wh_en) begin
      return 1'b1;
    end
    v = wh_col[2] ? col_sel(s, wh_col[1:0]) : col_sel(r, wh_col[1:0]);
    k = wh_num;
    case (wh_op)
      WOP_EQ:  return v == k;
      WOP_NE:  return v != k;
      WOP_GT:  return v > k;
      WOP_GE:  return v >= k;
      WOP_LT:  return v < k;
      WOP_LE:  return v <= k;
      default: return 1'b0;
    endcase
  endfunction

  task automatic join_predict(logic [1:0] op, row_t in_row);
    row_t         row;
    row_t         r;
    join_result_t res;
    int           hits;
    for (int j = 0; j < MAX_COLS; j++) row[j] = col_sel(in_row, j);
    res.status = ST_NO_MATCH;
    res.last   = 1'b1;
    res.r      = '0;
    res.s      = '0;
    case (op)
      OP_BUILD: begin
        if (stored_count < MAX_ROWS) begin
          stored_rows[stored_count] = row;
          stored_count++;
          res.status = ST_STORED;
        end else begin
          res.status = ST_FULL;
        end
        pending_results.insert(pending_results.size(), res);
      end
      OP_CLEAR: begin
        stored_count = 0;
        res.status = ST_CLEARED;
        pending_results.insert(pending_results.size(), res);
      end
      OP_PROBE: begin
        hits = 0;
        for (int i = 0; i < stored_count; i++) begin
          r = stored_rows[i];
          if (key_hit(col_sel(r, jn_r_key), col_sel(row, jn_s_key)) && where_ok(r, row)) begin
            res.status = ST_MATCH;
            res.last   = 1'b0;
            res.r      = r;
            res.s      = row;
            pending_results.insert(pending_results.size(), res);
            hits++;
          end
        end
        if (hits == 0) begin
          pending_results.insert(pending_results.size(), res);
        end else begin
          // Only the final pair of a probe carries the last flag.
          res = pending_results[pending_results.size() - 1];
          res.last = 1'b1;
          pending_results[pending_results.size() - 1] = res;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic apply_reg(logic [2:0] idx, col_t data);
    case (idx)
      REG_R_KEY_COL: jn_r_key = data[1:0];
      REG_S_KEY_COL: jn_s_key = data[1:0];
      REG_JOIN_MODE: jn_mode = data[1:0];
      REG_ARITH_NUM: jn_arith = data;
      REG_WHERE_EN:  wh_en = data[0];
      REG_WHERE_COL: wh_col = data[2:0];
      REG_WHERE_OP:  wh_op = data[2:0];
      REG_WHERE_NUM: wh_num = data;
      default: begin
      end
    endcase
  endtask

  task automatic check_result(join_result_t got);
    join_result_t want;
    logic [31:0]  w_f[10];
    logic [31:0]  g_f[10];
    if (pending_results.size() == 0) begin
      $display("%0t: result with no transfer pending, status %0d last %0d", $time,
               got.status, got.last);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    w_f[0] = 32'(want.status);
    w_f[1] = 32'(want.last);
    g_f[0] = 32'(got.status);
    g_f[1] = 32'(got.last);
    for (int j = 0; j < 4; j++) begin
      w_f[2 + j] = want.r[j];
      w_f[6 + j] = want.s[j];
      g_f[2 + j] = got.r[j];
      g_f[6 + j] = got.s[j];
    end
    for (int f = 0; f < 10; f++) begin
      if (g_f[f] !== w_f[f]) begin
        $display("%0t: %s expected %h, got %h", $time, field_name[f], w_f[f], g_f[f]);
        errors++;
      end
    end
  endtask

  // Sampling side: row transfers feed the predictor, result transfers are checked.
  logic         rows_fire = 1'b0;
  join_result_t seen;

  always @(posedge clk) begin
    rows_fire <= !rst && rows_if.valid && rows_if.ready;
    if (!rst && rows_if.valid && rows_if.ready) begin
      join_predict(rows_if.operation,
                   {rows_if.col_3, rows_if.col_2, rows_if.col_1, rows_if.col_0});
    end
    if (!rst && res_if.valid && res_if.ready) begin
      seen.status = res_if.status;
      seen.last   = res_if.last;
      seen.r      = {res_if.r_col_3, res_if.r_col_2, res_if.r_col_1, res_if.r_col_0};
      seen.s      = {res_if.s_col_3, res_if.s_col_2, res_if.s_col_1, res_if.s_col_0};
      check_result(seen);
    end
  end

  // Row sender: bursts of random length separated by random gaps.
  int        burst_left = 1;
  int        gap_left = 0;
  row_item_t next_row;

  always @(negedge clk) begin
    if (rst) begin
      rows_if.valid <= 1'b0;
    end else if (rows_if.valid && !rows_fire) begin
      // Hold the offered row until it is taken.
    end else if (gap_left > 0) begin
      rows_if.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (row_items.size() > 0 &&
                 !(row_items[0].drain && pending_results.size() != 0)) begin
      next_row = row_items.pop_front();
      rows_if.operation <= next_row.op;
      rows_if.col_0 <= next_row.cols[0];
      rows_if.col_1 <= next_row.cols[1];
      rows_if.col_2 <= next_row.cols[2];
      rows_if.col_3 <= next_row.cols[3];
      rows_if.valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 16);
        gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      rows_if.valid <= 1'b0;
    end
  end

  // Result receiver: switches between stall patterns every so often.
  int stall_mode = 0;
  int stall_left = 0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       res_if.ready <= 1'b1;
      1:       res_if.ready <= 1'($urandom_range(0, 1));
      2:       res_if.ready <= ($urandom_range(0, 3) == 0);
      default: res_if.ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  function automatic col_t rand_col();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return COL_MIN;
      3:       return COL_MAX;
      4:       return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic row_t random_row();
    row_t row;
    for (int j = 0; j < MAX_COLS; j++) row[j] = rand_col();
    return row;
  endfunction

  function automatic row_t mk_row(col_t c0, col_t c1, col_t c2, col_t c3);
    return {c3, c2, c1, c0};
  endfunction

  task automatic push_item(logic [1:0] op, row_t cols, bit drain);
    row_item_t item;
    item.op    = op;
    item.cols  = cols;
    item.drain = drain || ($urandom_range(0, 11) == 0);
    row_items.insert(row_items.size(), item);
  endtask

  task automatic new_pool(int n);
    pool_n = n;
    for (int i = 0; i < 4; i++) key_pool[i] = rand_col();
  endtask

  task automatic push_build();
    row_t row;
    row = random_row();
    row[jn_r_key] = key_pool[$urandom_range(0, pool_n - 1)];
    push_item(OP_BUILD, row, 1'b0);
  endtask

  // The probe key is chosen so that it pairs with one pool key under the join mode.
  task automatic push_probe(bit drain);
    row_t row;
    col_t k;
    row = random_row();
    k = key_pool[$urandom_range(0, pool_n - 1)];
    case (jn_mode)
      JOIN_ADD: row[jn_s_key] = jn_arith - k;
      JOIN_SUB: row[jn_s_key] = k - jn_arith;
      default:  row[jn_s_key] = k;
    endcase
    push_item(OP_PROBE, row, drain);
  endtask

  task automatic gen_mix(int n);
    int kind;
    if ($urandom_range(0, 1) == 1) begin
      push_item(OP_CLEAR, random_row(), 1'b0);
    end
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 19);
      if (kind < 8) begin
        push_build();
      end else if (kind < 17) begin
        push_probe(1'b0);
      end else if (kind == 17) begin
        push_item(OP_NOP, random_row(), 1'b0);
      end else if (kind == 18) begin
        push_item(OP_CLEAR, random_row(), 1'b0);
      end else begin
        push_item(OP_PROBE, random_row(), 1'b0);
      end
    end
  endtask

  task automatic write_reg(logic [2:0] idx, col_t data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    apply_reg(idx, data);
  endtask

  task automatic setup_phase(logic [1:0] rk, logic [1:0] sk, logic [1:0] mode, col_t arith,
                             logic wen, logic [2:0] wcol, logic [2:0] wop, col_t wnum);
    write_reg(REG_R_KEY_COL, {30'd0, rk});
    write_reg(REG_S_KEY_COL, {30'd0, sk});
    write_reg(REG_JOIN_MODE, {30'd0, mode});
    write_reg(REG_ARITH_NUM, arith);
    write_reg(REG_WHERE_EN, {31'd0, wen});
    write_reg(REG_WHERE_COL, {29'd0, wcol});
    write_reg(REG_WHERE_OP, {29'd0, wop});
    write_reg(REG_WHERE_NUM, wnum);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    // Items are queued at a rising edge so the sender never races the refill.
    @(posedge clk);
  endtask

  // Waits until every row is taken and answered, then lets the block settle.
  // The check runs at the rising edge, where the sender never changes anything.
  task automatic wait_idle();
    @(posedge clk);
    while (row_items.size() != 0 || rows_if.valid || pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    rows_if.valid = 1'b0;
    rows_if.operation = OP_BUILD;
    rows_if.col_0 = '0;
    rows_if.col_1 = '0;
    rows_if.col_2 = '0;
    rows_if.col_3 = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_R_KEY_COL;
    cfg_if.data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset configuration: equality join on column 0.
    push_item(OP_PROBE, mk_row(32'd5, 32'd1, 32'd2, 32'd3), 1'b0);
    push_item(OP_NOP, random_row(), 1'b0);
    push_item(OP_BUILD, mk_row('0, '0, '0, '0), 1'b0);
    push_item(OP_BUILD, mk_row(COL_MAX, COL_MIN, '1, 32'd1), 1'b0);
    push_item(OP_BUILD, mk_row(COL_MIN, COL_MAX, 32'd1, '1), 1'b0);
    push_item(OP_BUILD, mk_row(32'd5, 32'd1, 32'd2, 32'd3), 1'b0);
    push_item(OP_BUILD, mk_row(32'd5, 32'd4, 32'd5, 32'd6), 1'b0);
    push_item(OP_BUILD, mk_row('1, COL_MAX, COL_MIN, '0), 1'b0);
    push_item(OP_PROBE, mk_row(32'd5, COL_MIN, COL_MAX, '1), 1'b0);
    push_item(OP_PROBE, mk_row(COL_MAX, '0, '1, 32'd9), 1'b0);
    push_item(OP_PROBE, mk_row(COL_MIN, '1, '0, COL_MAX), 1'b0);
    push_item(OP_PROBE, mk_row('0, 32'd7, 32'd7, 32'd7), 1'b0);
    push_item(OP_PROBE, mk_row('1, 32'd3, 32'd2, 32'd1), 1'b1);
    push_item(OP_PROBE, mk_row(32'd77, '0, '0, '0), 1'b0);
    push_item(OP_NOP, mk_row('1, '1, '1, '1), 1'b0);
    push_item(OP_CLEAR, '0, 1'b0);
    push_item(OP_PROBE, mk_row(32'd5, 32'd1, 32'd2, 32'd3), 1'b0);
    push_item(OP_BUILD, mk_row(32'd5, 32'd8, 32'd8, 32'd8), 1'b0);
    push_item(OP_PROBE, mk_row(32'd5, 32'd9, 32'd9, 32'd9), 1'b0);
    wait_idle();

    new_pool(3);
    setup_phase(2'd3, 2'd0, JOIN_ADD, COL_MAX, 1'b0, 3'd7, WOP_NE, COL_MIN);
    gen_mix(5);
    wait_idle();

    new_pool(3);
    setup_phase(2'd2, 2'd1, JOIN_SUB, COL_MIN, 1'b1, 3'd1, WOP_GE, '0);
    gen_mix(5);
    wait_idle();

    // Fill the store past its limit, then probe it while it is full.
    new_pool(2);
    setup_phase(2'd0, 2'd3, JOIN_EQ, '0, 1'b1, 3'd4, WOP_LT, COL_MAX);
    push_item(OP_CLEAR, random_row(), 1'b0);
    repeat (MAX_ROWS + 2) push_build();
    push_probe(1'b1);
    repeat (2) push_probe(1'b0);
    push_item(OP_PROBE, random_row(), 1'b0);
    wait_idle();

    new_pool(3);
    setup_phase(2'd1, 2'd2, JOIN_NONE, '0, 1'b1, 3'd3, WOP_EQ, '0);
    gen_mix(2);
    wait_idle();

    new_pool(3);
    setup_phase(2'd0, 2'd0, JOIN_EQ, '0, 1'b1, 3'd2, WOP_RSVD_6, '0);
    gen_mix(2);
    wait_idle();

    new_pool(3);
    setup_phase(2'd3, 2'd3, JOIN_EQ, '0, 1'b1, 3'd6, WOP_RSVD_7, '0);
    gen_mix(2);
    wait_idle();

    new_pool(3);
    setup_phase(2'd2, 2'd2, JOIN_EQ, '0, 1'b1, 3'd7, WOP_LE, $urandom);
    gen_mix(2);
    wait_idle();

    // The where test on the build key only passes rows holding the first pool key.
    new_pool(2);
    setup_phase(2'd0, 2'd0, JOIN_EQ, '0, 1'b1, 3'd0, WOP_EQ, key_pool[0]);
    gen_mix(2);
    wait_idle();

    new_pool(3);
    setup_phase(2'd1, 2'd1, JOIN_ADD, '0, 1'b1, 3'd5, WOP_GT, COL_MIN);
    gen_mix(2);
    wait_idle();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
